// ===== sv/ctc_pkg.sv =====
package ctc_pkg;

    localparam int MAX_LEXEME_DEF = 128;
    localparam int KW_COUNT = 32;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_IDENT   = 4'd1,
        M_NUMBER  = 4'd2,
        M_STRING  = 4'd3,
        M_SLASH   = 4'd4,
        M_LINE    = 4'd5,
        M_BLOCK   = 4'd6,
        M_CHOPEN  = 4'd7,
        M_CHESC   = 4'd8,
        M_CHCLOSE = 4'd9,
        M_OPER    = 4'd10
    } mode_t;

    typedef enum logic [3:0] {
        C_KEYWORD = 4'd0,
        C_IDENT   = 4'd1,
        C_CHAR    = 4'd2,
        C_STRING  = 4'd3,
        C_SLASH   = 4'd4,
        C_ARITH   = 4'd5,
        C_LOGIC   = 4'd6,
        C_RELAT   = 4'd7,
        C_ASSIGN  = 4'd8,
        C_OTHER   = 4'd9,
        C_NUMBER  = 4'd10,
        C_COMMENT = 4'd11,
        C_EOF     = 4'd12,
        C_TYPE    = 4'd13,
        C_ERROR   = 4'd14
    } class_t;

    typedef struct packed {
        logic [3:0] token_class;
        logic [7:0] token_length;
        logic [4:0] keyword_number;
        logic       length_overflow;
    } result_t;

    localparam logic [31:0] TYPE_BITS = 32'h3133_1508;

    // keyword text, 8 chars max, zero padded, char 0 in low byte
    function automatic logic [63:0] kw_text(input logic [4:0] i);
        case (i)
            5'd0:  kw_text = {32'h0, "otua"};
            5'd1:  kw_text = {24'h0, "kaerb"};
            5'd2:  kw_text = {32'h0, "esac"};
            5'd3:  kw_text = {32'h0, "rahc"};
            5'd4:  kw_text = {24'h0, "tsnoc"};
            5'd5:  kw_text = "eunitnoc";
            5'd6:  kw_text = {8'h0, "tluafed"};
            5'd7:  kw_text = {48'h0, "od"};
            5'd8:  kw_text = {16'h0, "elbuod"};
            5'd9:  kw_text = {32'h0, "esle"};
            5'd10: kw_text = {32'h0, "mune"};
            5'd11: kw_text = {16'h0, "nretxe"};
            5'd12: kw_text = {24'h0, "taolf"};
            5'd13: kw_text = {40'h0, "rof"};
            5'd14: kw_text = {32'h0, "otog"};
            5'd15: kw_text = {48'h0, "fi"};
            5'd16: kw_text = {40'h0, "tni"};
            5'd17: kw_text = {32'h0, "gnol"};
            5'd18: kw_text = "retsiger";
            5'd19: kw_text = {16'h0, "nruter"};
            5'd20: kw_text = {24'h0, "trohs"};
            5'd21: kw_text = {16'h0, "dengis"};
            5'd22: kw_text = {16'h0, "foezis"};
            5'd23: kw_text = {16'h0, "citats"};
            5'd24: kw_text = {16'h0, "tcurts"};
            5'd25: kw_text = {16'h0, "hctiws"};
            5'd26: kw_text = {8'h0, "fedepyt"};
            5'd27: kw_text = {24'h0, "noinu"};
            5'd28: kw_text = "dengisnu";
            5'd29: kw_text = {32'h0, "diov"};
            5'd30: kw_text = "elitalov";
            default: kw_text = {24'h0, "elihw"};
        endcase
    endfunction

    function automatic logic [3:0] kw_len(input logic [4:0] i);
        logic [63:0] t;
        logic [3:0]  n;
        t = kw_text(i);
        n = 4'd0;
        for (int k = 0; k < 8; k++)
        begin
            if (t[8*k +: 8] != 8'h0)
                n = 4'(k + 1);
        end
        kw_len = n;
    endfunction

    function automatic logic is_special(input logic [7:0] c);
        is_special = c == "[" || c == "]" || c == "(" || c == ")" || c == "{" ||
                     c == "}" || c == "," || c == ";" || c == ":" || c == "?";
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        is_op = c == "=" || c == "+" || c == "-" || c == "*" || c == "/" ||
                c == "%" || c == "<" || c == ">" || c == "!" || c == "&" ||
                c == "|" || c == "^" || c == "~" || c == ".";
    endfunction

endpackage

// ===== sv/ctc_stream_if.sv =====
interface ctc_stream_if #(
    parameter int W = 8
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/ctc_scanner.sv =====
// Next-state and result logic for one character
module ctc_scanner #(
    parameter int MAX_LEXEME = ctc_pkg::MAX_LEXEME_DEF
) (
    input  ctc_pkg::mode_t   mode,
    input  logic [7:0]       pend,
    input  logic [7:0]       count,
    input  logic [31:0]      cand,
    input  logic             ovf,
    input  logic [7:0]       c,
    input  logic             eoi,
    output ctc_pkg::mode_t   mode_next,
    output logic [7:0]       pend_next,
    output logic [7:0]       count_next,
    output logic [31:0]      cand_next,
    output logic             ovf_next,
    output logic [1:0]       n_res,
    output ctc_pkg::result_t res0,
    output ctc_pkg::result_t res1
);
    localparam logic [7:0] MAXL = 8'(MAX_LEXEME);

    logic [31:0] kw_hit;
    logic [31:0] match_mask;
    logic [4:0]  kw_idx;
    logic        kw_any;
    ctc_pkg::result_t word_res;

    always_comb
    begin
        logic [63:0] t;
        for (int i = 0; i < 32; i++)
        begin
            t = ctc_pkg::kw_text(5'(i));
            kw_hit[i] = cand[i] && (8'(ctc_pkg::kw_len(5'(i))) == count);
            match_mask[i] = (count < 8'd8) && (t[8*count[2:0] +: 8] == c);
        end
    end

    always_comb
    begin
        kw_idx = 5'd0;
        kw_any = 1'b0;
        for (int i = 31; i >= 0; i--)
        begin
            if (kw_hit[i])
            begin
                kw_idx = 5'(i);
                kw_any = 1'b1;
            end
        end
        word_res.token_length = count;
        word_res.length_overflow = ovf;
        word_res.keyword_number = 5'd0;
        if (mode == ctc_pkg::M_NUMBER)
            word_res.token_class = ctc_pkg::C_NUMBER;
        else if (!ovf && kw_any)
        begin
            word_res.token_class = ctc_pkg::TYPE_BITS[kw_idx] ? ctc_pkg::C_TYPE
                                                               : ctc_pkg::C_KEYWORD;
            word_res.keyword_number = kw_idx;
        end
        else
            word_res.token_class = ctc_pkg::C_IDENT;
    end

    function automatic ctc_pkg::result_t mk(input ctc_pkg::class_t cls,
                                            input logic [7:0] len,
                                            input logic o);
        mk.token_class = cls;
        mk.token_length = len;
        mk.keyword_number = 5'd0;
        mk.length_overflow = o;
    endfunction

    function automatic ctc_pkg::class_t single(input logic [7:0] p);
        single = (p == "<" || p == ">") ? ctc_pkg::C_RELAT : ctc_pkg::C_ARITH;
    endfunction

    function automatic logic [31:0] match_mask_zero(input logic [7:0] ch);
        logic [63:0] t;
        for (int i = 0; i < 32; i++)
        begin
            t = ctc_pkg::kw_text(5'(i));
            match_mask_zero[i] = (t[7:0] == ch);
        end
    endfunction

    logic [7:0] cnt_inc;
    logic       ovf_inc;
    logic       do_start;
    logic       ends_w;

    assign cnt_inc = (count < MAXL) ? count + 8'd1 : count;
    assign ovf_inc = (count < MAXL) ? ovf : 1'b1;
    assign ends_w = ctc_pkg::is_special(c) || ctc_pkg::is_op(c) || c == " " ||
                    c == 8'h0a || c == 8'h09 || c == 8'h0d;

    always_comb
    begin
        logic emitted;
        mode_next  = mode;
        pend_next  = pend;
        count_next = count;
        cand_next  = cand;
        ovf_next   = ovf;
        n_res      = 2'd0;
        res0       = mk(ctc_pkg::C_EOF, 8'd0, 1'b0);
        res1       = mk(ctc_pkg::C_EOF, 8'd0, 1'b0);
        do_start   = 1'b0;
        emitted    = 1'b0;
        if (eoi)
        begin
            unique case (mode)
                ctc_pkg::M_IDENT, ctc_pkg::M_NUMBER: begin res0 = word_res; emitted = 1'b1; end
                ctc_pkg::M_STRING: begin res0 = mk(ctc_pkg::C_STRING, count, ovf); emitted = 1'b1; end
                ctc_pkg::M_SLASH: begin res0 = mk(ctc_pkg::C_SLASH, count, ovf); emitted = 1'b1; end
                ctc_pkg::M_LINE: begin res0 = mk(ctc_pkg::C_COMMENT, count, ovf); emitted = 1'b1; end
                ctc_pkg::M_BLOCK: begin res0 = mk(ctc_pkg::C_ERROR, count, ovf); emitted = 1'b1; end
                ctc_pkg::M_CHOPEN, ctc_pkg::M_CHESC, ctc_pkg::M_CHCLOSE:
                begin
                    res0 = mk(ctc_pkg::C_CHAR, count, ovf);
                    emitted = 1'b1;
                end
                ctc_pkg::M_OPER: begin res0 = mk(single(pend), count, ovf); emitted = 1'b1; end
                default: emitted = 1'b0;
            endcase
            if (emitted)
            begin
                n_res = 2'd2;
                res1 = mk(ctc_pkg::C_EOF, 8'd0, 1'b0);
            end
            else
            begin
                n_res = 2'd1;
                res0 = mk(ctc_pkg::C_EOF, 8'd0, 1'b0);
            end
            mode_next = ctc_pkg::M_IDLE;
            pend_next = 8'd0;
            count_next = 8'd0;
            cand_next = '1;
            ovf_next = 1'b0;
        end
        else
        begin
            unique case (mode)
                ctc_pkg::M_IDENT, ctc_pkg::M_NUMBER:
                begin
                    if (ends_w)
                    begin
                        res0 = word_res;
                        emitted = 1'b1;
                        do_start = 1'b1;
                    end
                    else
                    begin
                        if (mode == ctc_pkg::M_IDENT)
                            cand_next = cand & match_mask;
                        count_next = cnt_inc;
                        ovf_next = ovf_inc;
                    end
                end
                ctc_pkg::M_STRING:
                begin
                    if (c == 8'h22)
                    begin
                        res0 = mk(ctc_pkg::C_STRING, count, ovf);
                        emitted = 1'b1;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                        ovf_next = ovf_inc;
                    end
                end
                ctc_pkg::M_SLASH:
                begin
                    if (c == "/")
                    begin
                        mode_next = ctc_pkg::M_LINE;
                        count_next = 8'd0;
                    end
                    else if (c == "*")
                    begin
                        mode_next = ctc_pkg::M_BLOCK;
                        count_next = 8'd1;
                        pend_next = 8'd0;
                    end
                    else if (c == "=")
                    begin
                        res0 = mk(ctc_pkg::C_ASSIGN, 8'd2, ovf);
                        emitted = 1'b1;
                    end
                    else
                    begin
                        res0 = mk(ctc_pkg::C_SLASH, count, ovf);
                        emitted = 1'b1;
                        do_start = 1'b1;
                    end
                end
                ctc_pkg::M_LINE:
                begin
                    if (c == 8'h0a)
                    begin
                        res0 = mk(ctc_pkg::C_COMMENT, count, ovf);
                        emitted = 1'b1;
                    end
                    else
                    begin
                        count_next = cnt_inc;
                        ovf_next = ovf_inc;
                    end
                end
                ctc_pkg::M_BLOCK:
                begin
                    count_next = cnt_inc;
                    ovf_next = ovf_inc;
                    if (pend == "*" && c == "/")
                    begin
                        res0 = mk(ctc_pkg::C_COMMENT, cnt_inc, ovf_inc);
                        emitted = 1'b1;
                    end
                    else
                        pend_next = (c == "*") ? 8'h2a : 8'h00;
                end
                ctc_pkg::M_CHOPEN:
                begin
                    count_next = cnt_inc;
                    ovf_next = ovf_inc;
                    mode_next = (c == 8'h5c) ? ctc_pkg::M_CHESC : ctc_pkg::M_CHCLOSE;
                end
                ctc_pkg::M_CHESC:
                begin
                    count_next = cnt_inc;
                    ovf_next = ovf_inc;
                    mode_next = ctc_pkg::M_CHCLOSE;
                end
                ctc_pkg::M_CHCLOSE:
                begin
                    res0 = mk(ctc_pkg::C_CHAR, count, ovf);
                    emitted = 1'b1;
                end
                ctc_pkg::M_OPER:
                begin
                    emitted = 1'b1;
                    if ((pend == "=" || pend == "!" || pend == "<" || pend == ">") && c == "=")
                        res0 = mk(ctc_pkg::C_RELAT, 8'd2, ovf);
                    else if ((pend == "|" || pend == "&") && c == pend)
                        res0 = mk(ctc_pkg::C_LOGIC, 8'd2, ovf);
                    else if (!(pend == "=" || pend == "!" || pend == "<" || pend == ">" ||
                               pend == "|" || pend == "&") && c == "=")
                        res0 = mk(ctc_pkg::C_ASSIGN, 8'd2, ovf);
                    else
                    begin
                        res0 = mk(single(pend), count, ovf);
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase
            if (emitted || do_start)
            begin
                mode_next = ctc_pkg::M_IDLE;
                pend_next = 8'd0;
                count_next = 8'd0;
                cand_next = '1;
                ovf_next = 1'b0;
            end
            n_res = emitted ? 2'd1 : 2'd0;
            if (do_start)
            begin
                if (c == 8'h22)
                    mode_next = ctc_pkg::M_STRING;
                else if (c == "/")
                begin
                    mode_next = ctc_pkg::M_SLASH;
                    count_next = 8'd1;
                end
                else if (c == 8'h27)
                begin
                    mode_next = ctc_pkg::M_CHOPEN;
                    count_next = 8'd1;
                end
                else if (c >= "0" && c <= "9")
                begin
                    mode_next = ctc_pkg::M_NUMBER;
                    count_next = 8'd1;
                end
                else if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_")
                begin
                    mode_next = ctc_pkg::M_IDENT;
                    count_next = 8'd1;
                    cand_next = match_mask_zero(c);
                end
                else if (c == "^" || c == "~" || c == ".")
                begin
                    if (emitted)
                    begin
                        res1 = mk(ctc_pkg::C_OTHER, 8'd1, 1'b0);
                        n_res = 2'd2;
                    end
                    else
                    begin
                        res0 = mk(ctc_pkg::C_OTHER, 8'd1, 1'b0);
                        n_res = 2'd1;
                    end
                end
                else if (ctc_pkg::is_op(c))
                begin
                    mode_next = ctc_pkg::M_OPER;
                    pend_next = c;
                    count_next = 8'd1;
                end
            end
        end
    end

endmodule

// ===== sv/c_token_classifier_core.sv =====
// C token classifier.
// in  (sink):   one transaction per source byte, data = {end_of_input, char_in}.
// out (source): one transaction per token class result with token_class,
//               token_length, keyword_number, length_overflow, last_of_run.
// A byte may cause zero, one or two results; last_of_run marks the final one.
// Whitespace and brackets produce no result. end_of_input flushes the open
// token, emits end-of-file, and returns the scanner to its reset state.
// Timing: results are registered in the two-entry result buffer and leave
// from its head. Throughput: one byte per cycle while the receiver keeps up;
// a byte making two results waits until the result buffer will be empty
// after this cycle's pop, so it stalls when the byte before it also made
// two results.
// Stall: when out.ready is low, results wait in the buffer and in.ready
// drops once the buffer cannot take the results of the offered byte.
// Reset: asynchronous, clears scanner state and empties the buffer; the
// candidate mask resets to all ones.
module c_token_classifier_core #(
    parameter int MAX_LEXEME = ctc_pkg::MAX_LEXEME_DEF
) (
    input logic        clk,
    input logic        rst_n,
    ctc_stream_if.sink   in,
    ctc_stream_if.source out
);
    ctc_pkg::mode_t mode_reg, mode_next;
    logic [7:0]  pend_reg, pend_next;
    logic [7:0]  count_reg, count_next;
    logic [31:0] cand_reg, cand_next;
    logic        ovf_reg, ovf_next;
    logic [1:0]  n_res;
    ctc_pkg::result_t res0, res1;

    // two-entry buffer, entry 0 is head
    ctc_pkg::result_t buf_reg [2];
    logic             last_reg [2];
    logic [1:0]       fill_reg;
    logic             acc, pop;
    logic [1:0]       after_pop;

    ctc_scanner #(.MAX_LEXEME(MAX_LEXEME)) u_scan (
        .mode(mode_reg), .pend(pend_reg), .count(count_reg), .cand(cand_reg),
        .ovf(ovf_reg), .c(in.data[7:0]), .eoi(in.data[8]),
        .mode_next(mode_next), .pend_next(pend_next), .count_next(count_next),
        .cand_next(cand_next), .ovf_next(ovf_next), .n_res(n_res),
        .res0(res0), .res1(res1)
    );

    assign pop = out.valid && out.ready;
    assign after_pop = fill_reg - {1'b0, pop};
    assign in.ready = (after_pop == 2'd0) || (after_pop == 2'd1 && n_res != 2'd2);
    assign acc = in.valid && in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ctc_pkg::M_IDLE;
            pend_reg  <= 8'd0;
            count_reg <= 8'd0;
            cand_reg  <= '1;
            ovf_reg   <= 1'b0;
        end
        else if (acc)
        begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
            cand_reg  <= cand_next;
            ovf_reg   <= ovf_next;
        end
    end

    // with after_pop==1 a byte of zero or one result is safe; a two-result byte
    // needs after_pop==0. Bytes are admitted when their own results fit.
    logic [1:0] add;
    assign add = acc ? n_res : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 2'd0;
        else
            fill_reg <= after_pop + add;
    end

    always_ff @(posedge clk)
    begin
        if (add != 2'd0 && after_pop == 2'd0)
        begin
            buf_reg[0]  <= res0;
            last_reg[0] <= (n_res == 2'd1);
            buf_reg[1]  <= res1;
            last_reg[1] <= 1'b1;
        end
        else
        begin
            if (pop)
            begin
                buf_reg[0]  <= buf_reg[1];
                last_reg[0] <= last_reg[1];
            end
            if (add != 2'd0)
            begin
                buf_reg[1]  <= res0;
                last_reg[1] <= 1'b1;
            end
        end
    end

    assign out.valid = (fill_reg != 2'd0);
    assign out.data = {buf_reg[0], last_reg[0]};

    property p_fill_bound;
        @(posedge clk) disable iff (!rst_n) fill_reg != 2'd3;
    endproperty
    a_fill_bound: assert property (p_fill_bound) else $error("result buffer overrun");

    property p_two_needs_room;
        @(posedge clk) disable iff (!rst_n) (acc && n_res == 2'd2) |-> after_pop == 2'd0;
    endproperty
    a_two_needs_room: assert property (p_two_needs_room) else $error("no room for two results");

    property p_eof_reset;
        @(posedge clk) disable iff (!rst_n) (acc && in.data[8]) |=> mode_reg == ctc_pkg::M_IDLE;
    endproperty
    a_eof_reset: assert property (p_eof_reset) else $error("scanner not idle after eof");
endmodule
